// ----- rtl/ctw_pkg.sv -----
package ctw_pkg;

  localparam int PIXEL_BITS   = 8;
  localparam int HALF_WIN_W   = 4;
  localparam int HALF_WIN_H   = 3;
  localparam int WIN_W        = 2 * HALF_WIN_W;
  localparam int WIN_H        = 2 * HALF_WIN_H;
  localparam int CODE_W       = WIN_W * WIN_H - 1;
  localparam int CENTER_POS   = HALF_WIN_H * WIN_W + HALF_WIN_W;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int COL_OUT_W     = 10;
  localparam int ROW_W         = 12;
  localparam int CMP_W         = 14;

  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [WIN_H-1:0][PIXEL_BITS-1:0] pix_col_t;
  typedef logic [WIN_H-2:0][PIXEL_BITS-1:0] line_word_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_value;
    logic                  frame_start;
  } in_req_t;

  typedef struct packed {
    logic [CODE_W-1:0]    census_code;
    logic [COL_OUT_W-1:0] center_column;
    logic [ROW_W-1:0]     center_row;
    logic                 frame_end;
  } out_req_t;

endpackage

// ----- rtl/ctw_cell.sv -----
module ctw_cell
  import ctw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  pix_col_t         col_i,
  input  pixel_t           center_i,
  output pix_col_t         col_o,
  output logic [WIN_H-1:0] ge_o
);

  pix_col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  always_comb begin
    for (int i = 0; i < WIN_H; i++) begin
      ge_o[i] = (col_q[i] >= center_i);
    end
  end

  assign col_o = col_q;

endmodule

// ----- rtl/ctw_line_store.sv -----
module ctw_line_store
  import ctw_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  line_word_t        wr_word_i,
  output line_word_t        rd_word_o
);

  line_word_t mem [MAX_WIDTH];
  line_word_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_word_i;
    end
  end

  // A read of the column being written in the same cycle takes the new word.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_word_i;
      end else begin
        rd_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_word_o = rd_q;

endmodule

// ----- rtl/census_transform_window_top.sv -----
// Census transform over an 8 wide by 6 tall window on a raster pixel stream.
// Pixels enter on the input channel (valid/ready) in raster order; a request
// with frame_start set restarts the row and column counters at that pixel.
// Each pixel whose window center lies in the interior of the frame yields one
// request on the output channel with the 47-bit census code, the center
// coordinates and frame_end on the last code of the frame. Border centers
// yield nothing.
// While in_ready_o is high, one pixel is accepted every cycle: the line store
// is read and written once per pixel and the window is a row of eight column
// cells that shift by one per pixel.
// The output register holds a result while the receiver stalls; input is still
// taken until a second result is ready behind the waiting one, and only then
// does in_ready_o drop.
// Image width and height must be written via the configuration port while the
// block is idle; the block does not enforce this. Reset sets them to 640x480
// and clears counters, window and pipeline; the line store needs no reset.
module census_transform_window_top
  import ctw_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_req_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_req_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pix;
    logic [COL_W-1:0]      col;
    logic [ROW_W-1:0]      row;
    logic                  hit;
    logic                  fend;
  } stage_t;

  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic [COL_W-1:0]        col_q, col_d, c_cur;
  logic [ROW_W-1:0]        row_q, row_d, r_cur;
  logic [CMP_W-1:0]        w_eff, h_eff, c_ext, r_ext, c_inc, r_inc, ccol_full;
  logic                    adv, in_accept, hit, fend;
  logic                    s1_valid_q, s2_valid_q, out_valid_q;
  stage_t                  s1_q, s2_q;
  out_req_t                out_q;
  line_word_t              rd_word, wr_word;
  pix_col_t                colv;
  pix_col_t                cols [WIN_W];
  logic [WIN_H-1:0]        ge [WIN_W];
  logic [CODE_W-1:0]       code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_REG_W-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[HEIGHT_REG_W-1:0];
      endcase
    end
  end

  assign w_eff = (CMP_W'(width_q) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : CMP_W'(width_q);
  assign h_eff = (height_q > HEIGHT_REG_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT) : CMP_W'(height_q);

  assign adv       = !(out_valid_q && !out_ready_i && s2_valid_q && s2_q.hit);
  assign in_ready_o = adv;
  assign in_accept = in_valid_i && adv;

  assign c_cur = in_data_i.frame_start ? '0 : col_q;
  assign r_cur = in_data_i.frame_start ? '0 : row_q;
  assign c_ext = CMP_W'(c_cur);
  assign r_ext = CMP_W'(r_cur);
  assign c_inc = c_ext + CMP_W'(1);
  assign r_inc = r_ext + CMP_W'(1);

  assign hit  = (r_inc >= CMP_W'(WIN_H)) && (c_inc >= CMP_W'(WIN_W)) &&
                (r_ext + CMP_W'(2) <= h_eff) && (c_ext + CMP_W'(2) <= w_eff);
  assign fend = (r_ext + CMP_W'(2) == h_eff) && (c_ext + CMP_W'(2) == w_eff);

  always_comb begin
    if (c_inc >= w_eff) begin
      col_d = '0;
      row_d = (r_inc >= h_eff) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      col_d = c_inc[COL_W-1:0];
      row_d = r_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (adv) begin
        s1_valid_q <= in_accept;
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= '{pix: in_data_i.pixel_value, col: c_cur, row: r_cur, hit: hit, fend: fend};
    end
    if (adv && s1_valid_q) begin
      s2_q <= s1_q;
    end
  end

  ctw_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_accept),
    .rd_addr_i (c_cur),
    .wr_en_i   (adv && s1_valid_q),
    .wr_addr_i (s1_q.col),
    .wr_word_i (wr_word),
    .rd_word_o (rd_word)
  );

  always_comb begin
    for (int i = 0; i < WIN_H - 1; i++) begin
      colv[i] = rd_word[i];
    end
    colv[WIN_H-1] = s1_q.pix;
    for (int i = 0; i < WIN_H - 1; i++) begin
      wr_word[i] = colv[i+1];
    end
  end

  for (genvar j = 0; j < WIN_W; j++) begin : g_cell
    pix_col_t col_in;
    if (j == WIN_W - 1) begin : g_last
      assign col_in = colv;
    end else begin : g_mid
      assign col_in = cols[j+1];
    end
    ctw_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (adv && s1_valid_q),
      .col_i    (col_in),
      .center_i (cols[HALF_WIN_W][HALF_WIN_H]),
      .col_o    (cols[j]),
      .ge_o     (ge[j])
    );
  end

  always_comb begin
    code = '0;
    for (int i = 0; i < WIN_H; i++) begin
      for (int j = 0; j < WIN_W; j++) begin
        if (i * WIN_W + j < CENTER_POS) begin
          code[CODE_W - 1 - (i * WIN_W + j)] = ge[j][i];
        end else if (i * WIN_W + j > CENTER_POS) begin
          code[CODE_W - (i * WIN_W + j)] = ge[j][i];
        end
      end
    end
  end

  assign ccol_full = CMP_W'(s2_q.col) - CMP_W'(HALF_WIN_W - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && s2_valid_q && s2_q.hit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q && s2_q.hit) begin
      out_q.census_code   <= code;
      out_q.center_column <= ccol_full[COL_OUT_W-1:0];
      out_q.center_row    <= s2_q.row - ROW_W'(HALF_WIN_H - 1);
      out_q.frame_end     <= s2_q.fend;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_frame_start_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.frame_start |=> s1_q.col == '0 && s1_q.row == '0)
    else $error("frame start did not restart the counters");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(col_q) < CMP_W'(MAX_WIDTH))
    else $error("column counter beyond line store depth");

  a_out_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !(in_ready_o && s2_valid_q && s2_q.hit) |=> !out_valid_o)
    else $error("result repeated after it was taken");
`endif

endmodule
